// ===== hw/rtl/alzette_tweakable_block_cipher_assert.svh =====
// Assertion macros used by atbc_core.
`ifndef ALZETTE_TWEAKABLE_BLOCK_CIPHER_ASSERT_SVH
`define ALZETTE_TWEAKABLE_BLOCK_CIPHER_ASSERT_SVH

// ante |-> cons, same cycle
`define ATBC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atbc: implication check failed");

// ante |=> cons, next cycle
`define ATBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atbc: next-cycle check failed");

`endif

// ===== hw/rtl/atbc_pkg.sv =====
package atbc_pkg;

   localparam int MAX_ROUNDS     = 16;
   localparam int DEFAULT_ROUNDS = 14;
   localparam int KEY_DEPTH      = MAX_ROUNDS + 1;
   localparam int KIDX_W         = $clog2(KEY_DEPTH);
   localparam int WORD_W         = 32;
   localparam int CFG_W          = 64;
   localparam int RC_W           = 5;
   localparam int CSR_ADDR_W     = 5;
   localparam int REG_SHIFT      = 3;
   localparam int PHASE_W        = 2;

   typedef logic [WORD_W-1:0]  word_type;
   typedef word_type [3:0]     quad_type;
   typedef logic [KIDX_W-1:0]  kidx_type;
   typedef logic [PHASE_W-1:0] phase_type;

   localparam phase_type LAST_PHASE  = phase_type'(3);
   localparam logic      CMD_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ROUND,
      ST_WHITE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      REG_KEY_LOW,
      REG_KEY_HIGH,
      REG_TWEAK,
      REG_ROUNDS
   } reg_idx_type;

   localparam word_type ALZ_CONST [8] = '{
      32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
      32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
   };

   function automatic word_type rotr(input word_type v, input logic [4:0] n);
      logic [2*WORD_W-1:0] t;
      t = {v, v} >> n;
      return t[WORD_W-1:0];
   endfunction

   // rotation of b added into a, per Alzette step
   function automatic logic [4:0] rot_a(input phase_type p);
      case (p)
         2'd0:    return 5'd31;
         2'd1:    return 5'd17;
         2'd2:    return 5'd0;
         default: return 5'd24;
      endcase
   endfunction

   // rotation of a xored into b, per Alzette step
   function automatic logic [4:0] rot_b(input phase_type p);
      case (p)
         2'd0:    return 5'd24;
         2'd1:    return 5'd17;
         2'd2:    return 5'd31;
         default: return 5'd16;
      endcase
   endfunction

   function automatic kidx_type active_rounds(input logic [RC_W-1:0] rc);
      int r;
      r = int'(rc);
      if (r == 0) r = DEFAULT_ROUNDS;
      if (r > MAX_ROUNDS) r = MAX_ROUNDS;
      return kidx_type'(r);
   endfunction

endpackage

// ===== hw/rtl/atbc_if.sv =====
interface atbc_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   atbc_pkg::word_type in_word0;
   atbc_pkg::word_type in_word1;
   atbc_pkg::word_type in_word2;
   atbc_pkg::word_type in_word3;

   modport source (output valid, cmd, in_word0, in_word1, in_word2, in_word3, input ready);
   modport sink   (input valid, cmd, in_word0, in_word1, in_word2, in_word3, output ready);
endinterface

interface atbc_rsp_if;
   logic               valid;
   logic               ready;
   atbc_pkg::word_type out_word0;
   atbc_pkg::word_type out_word1;
   atbc_pkg::word_type out_word2;
   atbc_pkg::word_type out_word3;

   modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
   modport sink   (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

// ===== hw/rtl/alzette_tweakable_block_cipher.sv =====
// Channel   Direction  Transaction
// req       in         cmd + block words in_word0..3
// rsp       out        block words out_word0..3
// csr       in         APB writes/reads of key, tweak, round count
//
// R active rounds: a transaction runs one key fetch, four Alzette steps per round through the
// single shared ARX step unit and one whitening; the block takes no new request until the
// previous result has been taken.
// After a key or round-count write the 17-entry key store is rebuilt entry by entry;
// req.ready is low from the access cycle until the last entry is written
// and while a transaction is in flight.
// A result waits in the block register until rsp.ready; reset is synchronous.
module alzette_tweakable_block_cipher (
   input  logic                              clock,
   input  logic                              reset,
   atbc_req_if.sink                          req,
   atbc_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [atbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [atbc_pkg::CFG_W-1:0]        pwdata,
   output logic [atbc_pkg::CFG_W-1:0]        prdata,
   output logic                              pready
);
   import atbc_pkg::*;

   logic [CFG_W-1:0] key_low_ff, key_low_in;
   logic [CFG_W-1:0] key_high_ff, key_high_in;
   logic [CFG_W-1:0] tweak_ff, tweak_in;
   logic [RC_W-1:0]  rc_ff, rc_in;

   logic        wr_en;
   reg_idx_type wr_idx;
   logic        expand_start;
   logic        key_busy;
   kidx_type    key_addr;
   quad_type    key_data;
   kidx_type    steps;

   assign pready       = 1'b1;
   assign wr_en        = psel && penable && pwrite;
   assign wr_idx       = reg_idx_type'(paddr[CSR_ADDR_W-1:REG_SHIFT]);
   assign expand_start = wr_en && (wr_idx inside {REG_KEY_LOW, REG_KEY_HIGH, REG_ROUNDS});
   assign steps        = active_rounds(rc_ff);

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      tweak_in    = tweak_ff;
      rc_in       = rc_ff;
      if (wr_en) begin
         case (wr_idx)
            REG_KEY_LOW:  key_low_in  = pwdata;
            REG_KEY_HIGH: key_high_in = pwdata;
            REG_TWEAK:    tweak_in    = pwdata;
            REG_ROUNDS:   rc_in       = pwdata[RC_W-1:0];
            default:      rc_in       = rc_ff;
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         REG_KEY_LOW:  prdata = key_low_ff;
         REG_KEY_HIGH: prdata = key_high_ff;
         REG_TWEAK:    prdata = tweak_ff;
         REG_ROUNDS:   prdata = CFG_W'(rc_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         tweak_ff    <= '0;
         rc_ff       <= RC_W'(DEFAULT_ROUNDS);
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         tweak_ff    <= tweak_in;
         rc_ff       <= rc_in;
      end
   end

   atbc_key_sched u_key_sched (
      .clock    (clock),
      .reset    (reset),
      .start    (expand_start),
      .key_low  (key_low_ff),
      .key_high (key_high_ff),
      .rd_addr  (key_addr),
      .rd_data  (key_data),
      .busy     (key_busy)
   );

   atbc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .steps    (steps),
      .tweak    (tweak_ff),
      .key_busy (key_busy),
      .key_addr (key_addr),
      .key_data (key_data)
   );

endmodule

// ===== hw/rtl/atbc_ram.sv =====
module atbc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/atbc_arx_step.sv =====
module atbc_arx_step (
   input  logic                 dec,
   input  atbc_pkg::phase_type  phase,
   input  atbc_pkg::word_type   c0,
   input  atbc_pkg::word_type   c1,
   input  atbc_pkg::quad_type   blk_in,
   output atbc_pkg::quad_type   blk_out
);
   import atbc_pkg::*;

   phase_type inv_phase;

   assign inv_phase = LAST_PHASE - phase;

   // one Alzette step on both boxes; inverse step k undoes forward step 3-k
   always_comb begin
      word_type a;
      word_type b;
      word_type c;
      blk_out = blk_in;
      for (int l = 0; l < 2; l++) begin
         a = blk_in[2*l];
         b = blk_in[2*l+1];
         c = (l == 0) ? c0 : c1;
         if (dec) begin
            a = a ^ c;
            b = b ^ rotr(a, rot_b(inv_phase));
            a = a - rotr(b, rot_a(inv_phase));
         end else begin
            a = a + rotr(b, rot_a(phase));
            b = b ^ rotr(a, rot_b(phase));
            a = a ^ c;
         end
         blk_out[2*l]   = a;
         blk_out[2*l+1] = b;
      end
   end

endmodule

// ===== hw/rtl/atbc_key_sched.sv =====
module atbc_key_sched (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [atbc_pkg::CFG_W-1:0] key_low,
   input  logic [atbc_pkg::CFG_W-1:0] key_high,
   input  atbc_pkg::kidx_type      rd_addr,
   output atbc_pkg::quad_type      rd_data,
   output logic                    busy
);
   import atbc_pkg::*;

   logic     busy_ff, busy_in;
   kidx_type cnt_ff, cnt_in;
   quad_type prev_ff, prev_in;
   quad_type entry;
   kidx_type km1;

   assign km1 = cnt_ff - kidx_type'(1);

   always_comb begin
      if (cnt_ff == '0) begin
         entry = quad_type'({key_high, key_low});
      end else begin
         entry[0] = prev_ff[1];
         entry[1] = prev_ff[2] ^ prev_ff[3] ^ word_type'(km1);
         entry[2] = prev_ff[3];
         entry[3] = prev_ff[0] + prev_ff[1] + ALZ_CONST[3'(int'(km1) & 7)];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      prev_in = prev_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         prev_in = entry;
         if (cnt_ff == kidx_type'(MAX_ROUNDS)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + kidx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      prev_ff <= prev_in;
   end

   atbc_ram #(
      .WIDTH ($bits(quad_type)),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (busy_ff),
      .wr_addr (cnt_ff),
      .wr_data (entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy = busy_ff | start;

endmodule

// ===== hw/rtl/atbc_core.sv =====
`include "alzette_tweakable_block_cipher_assert.svh"

module atbc_core (
   input  logic                       clock,
   input  logic                       reset,
   atbc_req_if.sink                   req,
   atbc_rsp_if.source                 rsp,
   input  atbc_pkg::kidx_type         steps,
   input  logic [atbc_pkg::CFG_W-1:0] tweak,
   input  logic                       key_busy,
   output atbc_pkg::kidx_type         key_addr,
   input  atbc_pkg::quad_type         key_data
);
   import atbc_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   kidx_type  round_ff, round_in;
   kidx_type  key_idx_ff, key_idx_in;
   logic      dec_ff, dec_in;
   quad_type  blk_ff, blk_in;

   quad_type  twk_mask;
   quad_type  step_in;
   quad_type  step_out;
   quad_type  round_out;
   word_type  c0, c1;

   assign twk_mask = round_ff[0] ? quad_type'({64'd0, tweak}) : '0;
   assign c0 = ALZ_CONST[3'((int'(round_ff) * 2) & 7)];
   assign c1 = ALZ_CONST[3'((int'(round_ff) * 2 + 1) & 7)];

   always_comb begin
      step_in = blk_ff;
      if (phase_ff == '0) begin
         if (dec_ff) begin
            step_in[0] = blk_ff[2];
            step_in[1] = blk_ff[3];
            step_in[2] = blk_ff[0] ^ blk_ff[2];
            step_in[3] = blk_ff[1] ^ blk_ff[3];
         end else begin
            step_in = blk_ff ^ key_data ^ twk_mask;
         end
      end
   end

   atbc_arx_step u_arx (
      .dec     (dec_ff),
      .phase   (phase_ff),
      .c0      (c0),
      .c1      (c1),
      .blk_in  (step_in),
      .blk_out (step_out)
   );

   always_comb begin
      round_out = step_out;
      if (phase_ff == LAST_PHASE) begin
         if (dec_ff) begin
            round_out = step_out ^ key_data ^ twk_mask;
         end else begin
            round_out[0] = step_out[0] ^ step_out[2];
            round_out[1] = step_out[1] ^ step_out[3];
            round_out[2] = step_out[0];
            round_out[3] = step_out[1];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      round_in   = round_ff;
      key_idx_in = key_idx_ff;
      dec_in     = dec_ff;
      blk_in     = blk_ff;
      req.ready  = 1'b0;
      rsp.valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = !key_busy;
            if (req.valid && !key_busy) begin
               blk_in   = {req.in_word3, req.in_word2, req.in_word1, req.in_word0};
               dec_in   = (req.cmd == CMD_DECRYPT);
               phase_in = '0;
               if (req.cmd == CMD_DECRYPT) begin
                  key_idx_in = steps;
                  round_in   = steps - kidx_type'(1);
               end else begin
                  key_idx_in = '0;
                  round_in   = '0;
               end
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = dec_ff ? ST_WHITE : ST_ROUND;
         end
         ST_WHITE: begin
            blk_in = blk_ff ^ key_data;
            if (dec_ff) begin
               key_idx_in = steps - kidx_type'(1);
               state_in   = ST_ROUND;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROUND: begin
            blk_in   = round_out;
            phase_in = phase_ff + phase_type'(1);
            if (!dec_ff && phase_ff == LAST_PHASE - phase_type'(1)) begin
               key_idx_in = key_idx_ff + kidx_type'(1);
            end
            if (phase_ff == LAST_PHASE) begin
               if (dec_ff) begin
                  if (round_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     round_in   = round_ff - kidx_type'(1);
                     key_idx_in = key_idx_ff - kidx_type'(1);
                  end
               end else begin
                  if (round_ff == steps - kidx_type'(1)) begin
                     state_in = ST_WHITE;
                  end else begin
                     round_in = round_ff + kidx_type'(1);
                  end
               end
            end
         end
         ST_DONE: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= '0;
         round_ff   <= '0;
         key_idx_ff <= '0;
         dec_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         round_ff   <= round_in;
         key_idx_ff <= key_idx_in;
         dec_ff     <= dec_in;
      end
      blk_ff <= blk_in;
   end

   assign key_addr      = key_idx_ff;
   assign rsp.out_word0 = blk_ff[0];
   assign rsp.out_word1 = blk_ff[1];
   assign rsp.out_word2 = blk_ff[2];
   assign rsp.out_word3 = blk_ff[3];

   `ATBC_ASSERT_IMP(a_key_idx_bound, clock, reset, state_ff != ST_IDLE, key_idx_ff <= steps)
   `ATBC_ASSERT_IMP(a_round_bound, clock, reset, state_ff == ST_ROUND, round_ff < steps)
   `ATBC_ASSERT_IMP(a_enc_key_ahead, clock, reset, state_ff == ST_ROUND && phase_ff == LAST_PHASE && !dec_ff, key_idx_ff == round_ff + kidx_type'(1))
   `ATBC_ASSERT_IMP(a_done_entry, clock, reset, $rose(rsp.valid), $past(state_ff) == ST_WHITE || ($past(state_ff) == ST_ROUND && $past(phase_ff) == LAST_PHASE))

endmodule

// ===== bench/atbc_cipher_checker.sv =====
module atbc_cipher_checker
   import atbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   atbc_req_if                   req_mon,
   atbc_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CFG_W-1:0]      pwdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam word_type ROUND_CONST [8] = '{
      32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
      32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
   };

   logic [CFG_W-1:0] key_lo_q;
   logic [CFG_W-1:0] key_hi_q;
   logic [CFG_W-1:0] tweak_q;
   logic [RC_W-1:0]  rounds_q;
   quad_type         round_keys [KEY_DEPTH];
   quad_type         expected_blocks [$];
   int               mismatches = 0;

   function automatic word_type ror32(input word_type v, input int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic int effective_rounds();
      if (rounds_q == '0) return DEFAULT_ROUNDS;
      return (int'(rounds_q) > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_q);
   endfunction

   function automatic void rebuild_round_keys();
      quad_type p;
      quad_type n;
      round_keys[0] = {key_hi_q, key_lo_q};
      for (int i = 0; i < MAX_ROUNDS; i++) begin
         p = round_keys[i];
         n[3] = p[0] + p[1] + ROUND_CONST[i % 8];
         n[0] = p[1];
         n[1] = p[2] ^ p[3] ^ word_type'(i);
         n[2] = p[3];
         round_keys[i + 1] = n;
      end
   endfunction

   // returns {y, x}
   function automatic logic [63:0] alz_forward(input word_type x, input word_type y,
                                               input word_type c);
      word_type a;
      word_type b;
      a = x;
      b = y;
      a = a + ror32(b, 31); b = b ^ ror32(a, 24); a = a ^ c;
      a = a + ror32(b, 17); b = b ^ ror32(a, 17); a = a ^ c;
      a = a + b;            b = b ^ ror32(a, 31); a = a ^ c;
      a = a + ror32(b, 24); b = b ^ ror32(a, 16); a = a ^ c;
      return {b, a};
   endfunction

   function automatic logic [63:0] alz_inverse(input word_type x, input word_type y,
                                               input word_type c);
      word_type a;
      word_type b;
      a = x;
      b = y;
      a = a ^ c; b = b ^ ror32(a, 16); a = a - ror32(b, 24);
      a = a ^ c; b = b ^ ror32(a, 31); a = a - b;
      a = a ^ c; b = b ^ ror32(a, 17); a = a - ror32(b, 17);
      a = a ^ c; b = b ^ ror32(a, 24); a = a - ror32(b, 31);
      return {b, a};
   endfunction

   function automatic quad_type encrypt_block(input quad_type blk);
      quad_type w;
      word_type t;
      int       steps;
      w = blk;
      steps = effective_rounds();
      for (int i = 0; i < steps; i++) begin
         if (i % 2 == 1) begin
            w[0] ^= tweak_q[31:0];
            w[1] ^= tweak_q[63:32];
         end
         w = w ^ round_keys[i];
         {w[1], w[0]} = alz_forward(w[0], w[1], ROUND_CONST[(2 * i) % 8]);
         {w[3], w[2]} = alz_forward(w[2], w[3], ROUND_CONST[(2 * i + 1) % 8]);
         t = w[0] ^ w[2]; w[2] = w[0]; w[0] = t;
         t = w[1] ^ w[3]; w[3] = w[1]; w[1] = t;
      end
      return w ^ round_keys[steps];
   endfunction

   function automatic quad_type decrypt_block(input quad_type blk);
      quad_type w;
      word_type t;
      int       steps;
      steps = effective_rounds();
      w = blk ^ round_keys[steps];
      for (int i = steps - 1; i >= 0; i--) begin
         t = w[0] ^ w[2]; w[0] = w[2]; w[2] = t;
         t = w[1] ^ w[3]; w[1] = w[3]; w[3] = t;
         {w[1], w[0]} = alz_inverse(w[0], w[1], ROUND_CONST[(2 * i) % 8]);
         {w[3], w[2]} = alz_inverse(w[2], w[3], ROUND_CONST[(2 * i + 1) % 8]);
         w = w ^ round_keys[i];
         if (i % 2 == 1) begin
            w[0] ^= tweak_q[31:0];
            w[1] ^= tweak_q[63:32];
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin
      quad_type blk;
      quad_type got;
      quad_type want;
      if (reset) begin
         key_lo_q = '0;
         key_hi_q = '0;
         tweak_q  = '0;
         rounds_q = RC_W'(DEFAULT_ROUNDS);
         expected_blocks.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[CSR_ADDR_W-1:REG_SHIFT]))
               REG_KEY_LOW: begin
                  key_lo_q = pwdata;
                  rebuild_round_keys();
               end
               REG_KEY_HIGH: begin
                  key_hi_q = pwdata;
                  rebuild_round_keys();
               end
               REG_TWEAK: begin
                  tweak_q = pwdata;
               end
               REG_ROUNDS: begin
                  rounds_q = pwdata[RC_W-1:0];
                  rebuild_round_keys();
               end
               default: begin
               end
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_word3, rsp_mon.out_word2, rsp_mon.out_word1, rsp_mon.out_word0};
            if (expected_blocks.size() == 0) begin
               $error("unexpected result transaction: %h", got);
               mismatches++;
            end else begin
               want = expected_blocks.pop_front();
               for (int j = 0; j < 4; j++) begin
                  if (got[j] !== want[j]) begin
                     $error("out_word%0d: expected %h, actual %h", j, want[j], got[j]);
                     mismatches++;
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            blk = {req_mon.in_word3, req_mon.in_word2, req_mon.in_word1, req_mon.in_word0};
            if (req_mon.cmd == CMD_DECRYPT) expected_blocks.push_back(decrypt_block(blk));
            else expected_blocks.push_back(encrypt_block(blk));
         end
      end
      fail_count  <= mismatches;
      outstanding <= expected_blocks.size();
   end

endmodule

// ===== bench/tb_alzette_tweakable_block_cipher.sv =====
module tb_alzette_tweakable_block_cipher;
   import atbc_pkg::*;

   localparam int   RANDOM_ITEMS = 1300;
   localparam int   RUN_LIMIT    = 10000000;
   localparam int   DRAIN_CYCLES = 4 * MAX_ROUNDS + 8;
   localparam logic CMD_ENCRYPT  = ~CMD_DECRYPT;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CFG_W-1:0]      pwdata;
   logic [CFG_W-1:0]      prdata;
   logic                  pready;
   int                    fail_count;
   int                    outstanding;
   bit                    no_gaps = 1'b0;

   atbc_req_if req_ch ();
   atbc_rsp_if rsp_ch ();

   alzette_tweakable_block_cipher dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   atbc_cipher_checker cipher_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   initial begin
      #RUN_LIMIT;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   function automatic word_type random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      return $urandom;
   endfunction

   function automatic quad_type random_block();
      return {random_word(), random_word(), random_word(), random_word()};
   endfunction

   function automatic logic [CFG_W-1:0] random_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [RC_W-1:0] random_rounds();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return RC_W'($urandom_range(1, MAX_ROUNDS));
      if (r == 7) return '0;
      if (r == 8) return RC_W'($urandom_range(MAX_ROUNDS + 1, 31));
      return $urandom_range(0, 1) ? RC_W'(1) : RC_W'(MAX_ROUNDS);
   endfunction

   // result side back-pressure
   initial begin : rsp_stall
      int run_left;
      int stall_left;
      run_left = 0;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (run_left > 0) begin
            rsp_ch.ready <= 1'b1;
            run_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 30);
            stall_left = gap_length();
         end
      end
   end

   task automatic send_block(input logic op, input quad_type blk);
      int gap;
      gap = no_gaps ? 0 : gap_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= op;
      req_ch.in_word0 <= blk[0];
      req_ch.in_word1 <= blk[1];
      req_ch.in_word2 <= blk[2];
      req_ch.in_word3 <= blk[3];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_register(input reg_idx_type idx, input logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << REG_SHIFT;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // key store rebuild
      repeat (KEY_DEPTH + 3) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] klo, input logic [CFG_W-1:0] khi,
                            input logic [CFG_W-1:0] tw, input logic [RC_W-1:0] rc);
      write_register(REG_KEY_LOW, klo);
      write_register(REG_KEY_HIGH, khi);
      write_register(REG_TWEAK, tw);
      write_register(REG_ROUNDS, CFG_W'(rc));
   endtask

   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int random_sent;
      int n;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_ENCRYPT;
      req_ch.in_word0 <= '0;
      req_ch.in_word1 <= '0;
      req_ch.in_word2 <= '0;
      req_ch.in_word3 <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      configure('0, '0, '0, RC_W'(1));
      send_block(CMD_ENCRYPT, '0);
      send_block(CMD_DECRYPT, '0);
      send_block(CMD_ENCRYPT, '1);
      send_block(CMD_DECRYPT, '1);
      finish_phase();

      configure('1, '1, '1, RC_W'(MAX_ROUNDS));
      send_block(CMD_ENCRYPT, '0);
      send_block(CMD_DECRYPT, '0);
      send_block(CMD_ENCRYPT, '1);
      send_block(CMD_DECRYPT, '1);
      send_block(CMD_ENCRYPT, {4{32'hAAAA5555}});
      send_block(CMD_DECRYPT, {4{32'h5555AAAA}});
      finish_phase();

      // zero rounds falls back to the default, oversized counts saturate
      configure(random_value(), random_value(), random_value(), RC_W'(0));
      send_block(CMD_ENCRYPT, random_block());
      send_block(CMD_DECRYPT, random_block());
      finish_phase();
      configure(random_value(), random_value(), random_value(), RC_W'(31));
      send_block(CMD_ENCRYPT, random_block());
      send_block(CMD_DECRYPT, random_block());
      finish_phase();
      configure(random_value(), random_value(), random_value(), RC_W'(MAX_ROUNDS + 1));
      send_block(CMD_ENCRYPT, random_block());
      send_block(CMD_DECRYPT, random_block());
      finish_phase();
      configure(random_value(), random_value(), random_value(), RC_W'(2));
      send_block(CMD_ENCRYPT, random_block());
      send_block(CMD_DECRYPT, random_block());
      finish_phase();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) write_register(REG_KEY_LOW, random_value());
         if ($urandom_range(0, 3) != 0) write_register(REG_KEY_HIGH, random_value());
         if ($urandom_range(0, 3) != 0) write_register(REG_TWEAK, random_value());
         if ($urandom_range(0, 3) != 0) write_register(REG_ROUNDS, CFG_W'(random_rounds()));
         no_gaps = ($urandom_range(0, 3) == 0);
         n = $urandom_range(40, 160);
         if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
         repeat (n) begin
            send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, random_block());
            random_sent++;
         end
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/atbc_pkg.sv
hw/rtl/atbc_if.sv
hw/rtl/atbc_ram.sv
hw/rtl/atbc_arx_step.sv
hw/rtl/atbc_key_sched.sv
hw/rtl/atbc_core.sv
hw/rtl/alzette_tweakable_block_cipher.sv
bench/atbc_cipher_checker.sv
bench/tb_alzette_tweakable_block_cipher.sv
